>>> hdl/pglpb_pkg.sv
// Shared types, constants and the arctangent table of the polar grid binning core.
`default_nettype none
package pglpb_pkg;

    localparam int SECTOR_COUNT_DEF = 128;
    localparam int RING_COUNT_DEF   = 64;
    localparam int CORDIC_STEPS     = 30;
    localparam logic [14:0] MAX_RANGE_RESET = 15'd5000;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [6:0]         query_sector;
        logic [5:0]         query_ring;
    } t_cmd_item;

    typedef struct packed {
        logic               accepted;
        logic [6:0]         sector_id;
        logic [5:0]         ring_index;
        logic               became_lowest;
        logic               cell_occupied;
        logic [15:0]        cell_count;
        logic signed [15:0] lowest_height;
        logic [14:0]        lowest_range;
    } t_result;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pglpb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module pglpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hdl/polar_grid_lowest_point_binning_core.sv
// Top level of the polar grid lowest-point binning core.
// One command is taken at a time: start is honored while busy is low, and each command
// gives exactly one result strobe on o_res_valid that the receiver must take at once.
// An insert squares the coordinates, runs 30 shared CORDIC and square-root iterations (the
// root has RT bits, half the width of the scaled squared range rounded up: 23 at the default
// ring count), one restoring-division step per root bit, then the cell read-modify-write in
// the memory. A dropped insert ends after the squaring and sum with an all-zero result; a read
// addresses the cell and then reports it; a reserved command gives an all-zero result. A clear
// walks the cell memory one entry a cycle; the same clearing pass over all 8192 entries at the
// default size runs after reset with busy high. The max_range register may be written
// at any time the core is idle.
`default_nettype none
module polar_grid_lowest_point_binning_core #(
    parameter int SECTOR_COUNT = pglpb_pkg::SECTOR_COUNT_DEF,
    parameter int RING_COUNT   = pglpb_pkg::RING_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pglpb_pkg::t_cmd_item i_cmd,
    input  wire logic                 i_cfg_we,
    input  wire logic [14:0]          i_cfg_wdata,
    output logic                      o_res_valid,
    output pglpb_pkg::t_result        o_res
);

    localparam int SEC_W    = $clog2(SECTOR_COUNT);
    localparam int RING_W   = $clog2(RING_COUNT);
    localparam int CELLS    = SECTOR_COUNT * RING_COUNT;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int RC2      = RING_COUNT * RING_COUNT;
    localparam int RC2_W    = $clog2(RC2 + 1);
    localparam int SQ_W     = ((32 + RC2_W + 1) / 2) * 2;
    localparam int RT_W     = SQ_W / 2;
    localparam int MEM_W    = 47;
    localparam int CNT_W    = $clog2(RT_W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQUARE, S_SUM, S_SCALE, S_ITER, S_DIV, S_BIN, S_ADDR, S_RMW,
        S_QADDR, S_QRES, S_CLEAR
    } t_state;

    t_state               r_state;
    pglpb_pkg::t_cmd_item r_item;
    logic [14:0]          r_max;
    logic [30:0]          r_xx, r_yy, r_zz;
    logic [31:0]          r_h2;
    logic signed [33:0]   r_px, r_py;
    logic [31:0]          r_ang;
    logic                 r_ang_fix;
    logic [4:0]           r_it;
    logic [SQ_W-1:0]      r_sq_val  [2];
    logic [RT_W+1:0]      r_sq_rem  [2];
    logic [RT_W-1:0]      r_sq_root [2];
    logic [RT_W-1:0]      r_dnum, r_q;
    logic [15:0]          r_drem;
    logic [CNT_W-1:0]     r_dcnt;
    logic [SEC_W-1:0]     r_sec;
    logic [RING_W-1:0]    r_ring;
    logic [14:0]          r_hr;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_clr;
    logic                 r_clr_res;
    logic                 r_qok;
    logic                 r_res_valid;
    pglpb_pkg::t_result   r_res;

    logic signed [31:0]   sq_x, sq_y, sq_z;
    logic [31:0]          d2;
    logic [29:0]          lim;
    logic                 drop;
    logic [SQ_W-1:0]      scaled;
    logic signed [33:0]   dx, dy;
    logic [RT_W+3:0]      sq_t     [2];
    logic [RT_W+3:0]      sq_trial [2];
    logic [RT_W+1:0]      n_sq_rem [2];
    logic [RT_W-1:0]      n_sq_root[2];
    logic [15:0]          div_t;
    logic                 div_ge;
    logic [32+SEC_W-1:0]  sec_prod;
    logic [31:0]          ins_addr, q_addr;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [MEM_W-1:0]     ram_wdata, ram_rdata;
    logic [15:0]          m_cnt, n_cnt;
    logic signed [15:0]   m_hgt;
    logic [14:0]          m_rng;
    logic                 low;
    pglpb_pkg::t_result   read_res;
    logic                 n_res_valid;

    always_comb begin
        sq_x     = r_item.point_x * r_item.point_x;
        sq_y     = r_item.point_y * r_item.point_y;
        sq_z     = r_item.point_z * r_item.point_z;
        d2       = 32'(r_xx) + 32'(r_yy) + 32'(r_zz);
        lim      = r_max * r_max;
        drop     = (r_max == 15'd0) || (d2 >= 32'(lim));
        scaled   = SQ_W'(r_h2) * SQ_W'(RC2);
        dx       = r_py >>> r_it;
        dy       = r_px >>> r_it;
        for (int k = 0; k < 2; k++) begin
            sq_t[k]     = {r_sq_rem[k], r_sq_val[k][SQ_W-1 -: 2]};
            sq_trial[k] = {2'b00, r_sq_root[k], 2'b01};
            if (sq_t[k] >= sq_trial[k]) begin
                n_sq_rem[k]  = (RT_W+2)'(sq_t[k] - sq_trial[k]);
                n_sq_root[k] = {r_sq_root[k][RT_W-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = (RT_W+2)'(sq_t[k]);
                n_sq_root[k] = {r_sq_root[k][RT_W-2:0], 1'b0};
            end
        end
        div_t    = {r_drem[14:0], r_dnum[RT_W-1]};
        div_ge   = div_t >= {1'b0, r_max};
        sec_prod = r_ang * (32+SEC_W)'(SECTOR_COUNT);
        ins_addr = 32'(r_sec) * 32'(RING_COUNT) + 32'(r_ring);
        q_addr   = 32'(r_item.query_sector) * 32'(RING_COUNT) + 32'(r_item.query_ring);
        m_cnt    = ram_rdata[46:31];
        m_hgt    = ram_rdata[30:15];
        m_rng    = ram_rdata[14:0];
        low      = (m_cnt == 16'd0) || (r_item.point_z < m_hgt);
        n_cnt    = (m_cnt == 16'hFFFF) ? m_cnt : m_cnt + 16'd1;
        read_res            = '0;
        read_res.sector_id  = r_item.query_sector;
        read_res.ring_index = r_item.query_ring;
        if (r_qok && m_cnt != 16'd0) begin
            read_res.cell_occupied = 1'b1;
            read_res.cell_count    = m_cnt;
            read_res.lowest_height = m_hgt;
            read_res.lowest_range  = m_rng;
        end
        case (r_state)
            S_IDLE:  n_res_valid = start && !(i_cmd.command inside {pglpb_pkg::CMD_CLEAR,
                                       pglpb_pkg::CMD_INSERT, pglpb_pkg::CMD_READ});
            S_SUM:   n_res_valid = drop;
            S_RMW:   n_res_valid = 1'b1;
            S_QRES:  n_res_valid = 1'b1;
            S_CLEAR: n_res_valid = r_clr_res && (r_clr == ADDR_W'(CELLS - 1));
            default: n_res_valid = 1'b0;
        endcase
        ram_raddr = (r_state == S_QADDR) ? ADDR_W'(q_addr) : ADDR_W'(ins_addr);
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
        end else if (r_state == S_RMW) begin
            ram_we    = 1'b1;
            ram_wdata = low ? {n_cnt, r_item.point_z, r_hr} : {n_cnt, m_hgt, m_rng};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_res   <= 1'b0;
            r_res_valid <= 1'b0;
            r_max       <= pglpb_pkg::MAX_RANGE_RESET;
        end else begin
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item <= i_cmd;
                        case (i_cmd.command)
                            pglpb_pkg::CMD_CLEAR: begin
                                r_clr     <= '0;
                                r_clr_res <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            pglpb_pkg::CMD_INSERT: r_state <= S_SQUARE;
                            pglpb_pkg::CMD_READ:   r_state <= S_QADDR;
                            default: begin
                                r_res <= '0;
                            end
                        endcase
                    end
                end
                S_SQUARE: begin
                    r_xx    <= 31'(sq_x);
                    r_yy    <= 31'(sq_y);
                    r_zz    <= 31'(sq_z);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_h2 <= 32'(r_xx) + 32'(r_yy);
                    if (drop) begin
                        r_res   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_sq_val[0]  <= SQ_W'(r_h2);
                    r_sq_val[1]  <= scaled;
                    r_sq_rem[0]  <= '0;
                    r_sq_rem[1]  <= '0;
                    r_sq_root[0] <= '0;
                    r_sq_root[1] <= '0;
                    r_it         <= '0;
                    if (r_item.point_y == 16'sd0) begin
                        r_ang_fix <= 1'b1;
                        r_ang     <= r_item.point_x[15] ? 32'h80000000 : 32'h0;
                    end else begin
                        r_ang_fix <= 1'b0;
                        if (r_item.point_x[15]) begin
                            r_px  <= -(34'(r_item.point_x) <<< 14);
                            r_py  <= -(34'(r_item.point_y) <<< 14);
                            r_ang <= 32'h80000000;
                        end else begin
                            r_px  <= 34'(r_item.point_x) <<< 14;
                            r_py  <= 34'(r_item.point_y) <<< 14;
                            r_ang <= 32'h0;
                        end
                    end
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (!r_ang_fix) begin
                        if (r_py > 34'sd0) begin
                            r_px  <= r_px + dx;
                            r_py  <= r_py - dy;
                            r_ang <= r_ang + pglpb_pkg::atan_turn(r_it);
                        end else begin
                            r_px  <= r_px - dx;
                            r_py  <= r_py + dy;
                            r_ang <= r_ang - pglpb_pkg::atan_turn(r_it);
                        end
                    end
                    if (32'(r_it) < RT_W) begin
                        for (int k = 0; k < 2; k++) begin
                            r_sq_val[k]  <= r_sq_val[k] << 2;
                            r_sq_rem[k]  <= n_sq_rem[k];
                            r_sq_root[k] <= n_sq_root[k];
                        end
                    end
                    r_it <= r_it + 5'd1;
                    if (32'(r_it) == pglpb_pkg::CORDIC_STEPS - 1) begin
                        r_dnum  <= r_sq_root[1];
                        r_drem  <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= div_ge ? div_t - {1'b0, r_max} : div_t;
                    r_q    <= {r_q[RT_W-2:0], div_ge};
                    r_dnum <= r_dnum << 1;
                    r_dcnt <= r_dcnt + CNT_W'(1);
                    if (32'(r_dcnt) == RT_W - 1) begin
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_sec   <= sec_prod[32 +: SEC_W];
                    r_ring  <= (32'(r_q) >= 32'(RING_COUNT)) ? RING_W'(RING_COUNT - 1)
                                                            : RING_W'(r_q);
                    r_hr    <= r_sq_root[0][14:0];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= ADDR_W'(ins_addr);
                    r_state <= S_RMW;
                end
                S_RMW: begin
                    r_res.accepted      <= 1'b1;
                    r_res.sector_id     <= 7'(r_sec);
                    r_res.ring_index    <= 6'(r_ring);
                    r_res.became_lowest <= low;
                    r_res.cell_occupied <= 1'b1;
                    r_res.cell_count    <= n_cnt;
                    r_res.lowest_height <= low ? r_item.point_z : m_hgt;
                    r_res.lowest_range  <= low ? r_hr : m_rng;
                    r_state             <= S_IDLE;
                end
                S_QADDR: begin
                    r_qok   <= (32'(r_item.query_sector) < 32'(SECTOR_COUNT)) &&
                               (32'(r_item.query_ring) < 32'(RING_COUNT));
                    r_state <= S_QRES;
                end
                S_QRES: begin
                    r_res   <= read_res;
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(CELLS - 1)) begin
                        if (r_clr_res) begin
                            r_res <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pglpb_ram #(
        .WIDTH(MEM_W),
        .DEPTH(CELLS)
    ) u_cells (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

>>> hdl/pglpb_checker.sv
// Port-level assertions of the polar grid binning core and their bind statement.
`default_nettype none
module pglpb_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_res_valid,
    input wire pglpb_pkg::t_result   o_res
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_res_valid)
        else $error("An accepted transfer neither raised busy nor produced a result.");

    a_lowest_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.became_lowest |-> o_res.accepted)
        else $error("A result marked new lowest was not an accepted point.");

    a_empty_has_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.cell_occupied |-> o_res.cell_count == 16'd0)
        else $error("An empty cell reported a nonzero count.");

    a_accept_occupies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.accepted |-> o_res.cell_occupied && o_res.cell_count != 16'd0)
        else $error("An accepted point left its cell empty.");

endmodule

bind polar_grid_lowest_point_binning_core pglpb_checker u_pglpb_checker (.*);
`default_nettype wire
